>>> src/i2ctw_pkg.sv
// Shared types, widths and the sequencer microcode for the I2C timing word calculator.
// No dependencies.
`default_nettype none
package i2ctw_pkg;

  localparam int CLK_W   = 30;
  localparam int BUS_W   = 20;
  localparam int DIVR_W  = 24;  // holds (prescaler + 1) * bus_hz for up to 16 prescalers
  localparam int PRESC_W = 4;
  localparam int DLY_W   = 4;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 5;   // divider bit counter, indexes CLK_W bits
  localparam int IDX_W   = 2;
  localparam int STEP_W  = 4;

  localparam logic [WORD_W-1:0] FALLBACK_RESET = 32'h0030_3D5B;
  localparam logic [DLY_W-1:0]  SETUP_RESET    = 4'd4;
  localparam logic [DLY_W-1:0]  DATA_RESET     = 4'd2;
  localparam logic [CLK_W-1:0]  MIN_PERIOD     = 30'd4;
  localparam logic [CLK_W-1:0]  MAX_PERIOD     = 30'd512;
  localparam logic [9:0]        PERIOD_OFFSET  = 10'd2;

  localparam logic [IDX_W-1:0] REG_FALLBACK = 2'd0;
  localparam logic [IDX_W-1:0] REG_SETUP    = 2'd1;
  localparam logic [IDX_W-1:0] REG_DATA     = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_ZCHK   = 4'd1;
  localparam step_t S_DINIT  = 4'd2;
  localparam step_t S_DSTEP  = 4'd3;
  localparam step_t S_CHECK  = 4'd4;
  localparam step_t S_LAST   = 4'd5;
  localparam step_t S_NEXT   = 4'd6;
  localparam step_t S_PACK   = 4'd7;
  localparam step_t S_FALLBK = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DINIT,
    OP_DSTEP,
    OP_NEXT,
    OP_PACK,
    OP_FALLBK
  } op_t;

  typedef enum logic [2:0] {
    C_SEQ,
    C_ALWAYS,
    C_NO_BEAT,
    C_ZERO,
    C_DIV_BUSY,
    C_FIT,
    C_LAST,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  ret;     // fall through to S_WAIT instead of the next step
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

  function automatic uword_t ucode(input step_t step);
    uword_t uw;
    case (step)
      S_WAIT:   uw = '{op: OP_LOAD,   cond: C_NO_BEAT,  target: S_WAIT,   ret: 1'b0};
      S_ZCHK:   uw = '{op: OP_NOP,    cond: C_ZERO,     target: S_FALLBK, ret: 1'b0};
      S_DINIT:  uw = '{op: OP_DINIT,  cond: C_SEQ,      target: S_WAIT,   ret: 1'b0};
      S_DSTEP:  uw = '{op: OP_DSTEP,  cond: C_DIV_BUSY, target: S_DSTEP,  ret: 1'b0};
      S_CHECK:  uw = '{op: OP_NOP,    cond: C_FIT,      target: S_PACK,   ret: 1'b0};
      S_LAST:   uw = '{op: OP_NOP,    cond: C_LAST,     target: S_FALLBK, ret: 1'b0};
      S_NEXT:   uw = '{op: OP_NEXT,   cond: C_ALWAYS,   target: S_DINIT,  ret: 1'b0};
      S_PACK:   uw = '{op: OP_PACK,   cond: C_OUT_BUSY, target: S_PACK,   ret: 1'b1};
      S_FALLBK: uw = '{op: OP_FALLBK, cond: C_OUT_BUSY, target: S_FALLBK, ret: 1'b1};
      default:  uw = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_WAIT,   ret: 1'b0};
    endcase
    return uw;
  endfunction

endpackage
`default_nettype wire

>>> src/i2ctw_if.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on i2ctw_pkg for widths.
`default_nettype none
interface i2ctw_req_if;
  logic                          valid;
  logic                          ready;
  logic [i2ctw_pkg::CLK_W-1:0]   clock_hz;
  logic [i2ctw_pkg::BUS_W-1:0]   bus_hz;
  modport source (output valid, output clock_hz, output bus_hz, input ready);
  modport sink   (input valid, input clock_hz, input bus_hz, output ready);
endinterface

interface i2ctw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [i2ctw_pkg::WORD_W-1:0]  timing_word;
  logic                          used_fallback;
  modport source (output valid, output timing_word, output used_fallback, input ready);
  modport sink   (input valid, input timing_word, input used_fallback, output ready);
endinterface

interface i2ctw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [i2ctw_pkg::IDX_W-1:0]   index;
  logic [i2ctw_pkg::WORD_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/i2ctw_div.sv
// Restoring divider, one quotient bit per cycle under sequencer control.
// Depends on i2ctw_pkg.
`default_nettype none
module i2ctw_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire i2ctw_pkg::div_ctrl_t            ctrl,
  input  wire logic [i2ctw_pkg::CLK_W-1:0]     dividend,
  input  wire logic [i2ctw_pkg::DIVR_W-1:0]    divisor,
  output logic      [i2ctw_pkg::CLK_W-1:0]     quot,
  output i2ctw_pkg::div_stat_t                 stat
);

  logic [i2ctw_pkg::DIVR_W-1:0] rem;
  logic [i2ctw_pkg::CNT_W-1:0]  cnt;
  logic [i2ctw_pkg::DIVR_W:0]   trial;
  logic                         fits;

  assign trial     = {rem, quot[i2ctw_pkg::CLK_W-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign stat.busy = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= i2ctw_pkg::CNT_W'(i2ctw_pkg::CLK_W - 1);
    end else if (ctrl.step && stat.busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem  <= '0;
      quot <= dividend;
    end else if (ctrl.step) begin
      rem  <= fits ? i2ctw_pkg::DIVR_W'(trial - {1'b0, divisor})
                   : i2ctw_pkg::DIVR_W'(trial);
      quot <= {quot[i2ctw_pkg::CLK_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> src/i2c_timing_word_calculator.sv
// I2C timing word calculator: microcoded sequencer around a bit-serial divider.
// Depends on i2ctw_pkg, i2ctw_if and i2ctw_div.
//
// Usage:
//   req  (sink)  : one beat carries clock_hz and bus_hz.
//   rsp  (source): one beat per request with timing_word and used_fallback.
//   cfg  (sink)  : register writes, always ready; index 0 fallback_word,
//                  1 setup_delay, 2 data_delay, index 3 ignored. Write only
//                  while no request is in flight.
//   A program of nine steps in a constant table runs each request. Each
//   prescaler trial takes one divider load, the divide steps (one quotient
//   bit per cycle) and the check steps. req.ready is high only at
//   the wait step, so a new request is taken only after the last one has
//   run its program to the end. The result sits in an output register; the
//   next request is taken while it waits. A stalled receiver holds the block
//   at its final step until the output register frees up.
//   Reset restores the register defaults and empties the output register.
`default_nettype none
module i2c_timing_word_calculator #(
  parameter int MAX_PRESCALER = 15
) (
  input  wire logic   clk,
  input  wire logic   rst,
  i2ctw_req_if.sink   req,
  i2ctw_rsp_if.source rsp,
  i2ctw_cfg_if.sink   cfg
);

  logic [i2ctw_pkg::WORD_W-1:0]  fallback_word;
  logic [i2ctw_pkg::DLY_W-1:0]   setup_delay;
  logic [i2ctw_pkg::DLY_W-1:0]   data_delay;

  i2ctw_pkg::step_t               step;
  i2ctw_pkg::step_t               step_next;
  i2ctw_pkg::uword_t              uw;
  logic                           jump;

  logic [i2ctw_pkg::CLK_W-1:0]   clk_r;
  logic [i2ctw_pkg::BUS_W-1:0]   bus_r;
  logic [i2ctw_pkg::DIVR_W-1:0]  divisor;
  logic [i2ctw_pkg::PRESC_W-1:0] presc;

  logic [i2ctw_pkg::CLK_W-1:0]   quot;
  i2ctw_pkg::div_ctrl_t           div_ctrl;
  i2ctw_pkg::div_stat_t           div_stat;

  logic                           out_valid;
  logic                           out_busy;
  logic                           beat_in;
  logic                           fit;
  logic [8:0]                     total;
  logic [7:0]                     low;
  logic [7:0]                     high;

  assign uw       = i2ctw_pkg::ucode(step);
  assign beat_in  = req.valid && req.ready;
  assign out_busy = out_valid && !rsp.ready;
  assign fit      = quot >= i2ctw_pkg::MIN_PERIOD && quot <= i2ctw_pkg::MAX_PERIOD;
  assign total    = 9'(quot[9:0] - i2ctw_pkg::PERIOD_OFFSET);
  assign high     = total[8:1];
  assign low      = total[8:1] + {7'b0, total[0]};

  assign req.ready = step == i2ctw_pkg::S_WAIT;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;

  assign div_ctrl.load = uw.op == i2ctw_pkg::OP_DINIT;
  assign div_ctrl.step = uw.op == i2ctw_pkg::OP_DSTEP;

  i2ctw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (clk_r),
    .divisor  (divisor),
    .quot     (quot),
    .stat     (div_stat)
  );

  always_comb begin
    case (uw.cond)
      i2ctw_pkg::C_SEQ:      jump = 1'b0;
      i2ctw_pkg::C_ALWAYS:   jump = 1'b1;
      i2ctw_pkg::C_NO_BEAT:  jump = !req.valid;
      i2ctw_pkg::C_ZERO:     jump = clk_r == '0 || bus_r == '0;
      i2ctw_pkg::C_DIV_BUSY: jump = div_stat.busy;
      i2ctw_pkg::C_FIT:      jump = fit;
      i2ctw_pkg::C_LAST:     jump = presc == i2ctw_pkg::PRESC_W'(MAX_PRESCALER);
      i2ctw_pkg::C_OUT_BUSY: jump = out_busy;
      default:               jump = 1'b0;
    endcase
    if (jump) begin
      step_next = uw.target;
    end else if (uw.ret) begin
      step_next = i2ctw_pkg::S_WAIT;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= i2ctw_pkg::S_WAIT;
      out_valid     <= 1'b0;
      fallback_word <= i2ctw_pkg::FALLBACK_RESET;
      setup_delay   <= i2ctw_pkg::SETUP_RESET;
      data_delay    <= i2ctw_pkg::DATA_RESET;
    end else begin
      step <= step_next;
      if ((uw.op == i2ctw_pkg::OP_PACK || uw.op == i2ctw_pkg::OP_FALLBK) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          i2ctw_pkg::REG_FALLBACK: fallback_word <= cfg.data;
          i2ctw_pkg::REG_SETUP:    setup_delay   <= cfg.data[i2ctw_pkg::DLY_W-1:0];
          i2ctw_pkg::REG_DATA:     data_delay    <= cfg.data[i2ctw_pkg::DLY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath, driven by the control word
  always_ff @(posedge clk) begin
    case (uw.op)
      i2ctw_pkg::OP_LOAD: begin
        if (beat_in) begin
          clk_r   <= req.clock_hz;
          bus_r   <= req.bus_hz;
          divisor <= i2ctw_pkg::DIVR_W'(req.bus_hz);
          presc   <= '0;
        end
      end
      i2ctw_pkg::OP_NEXT: begin
        divisor <= divisor + i2ctw_pkg::DIVR_W'(bus_r);
        presc   <= presc + 1'b1;
      end
      i2ctw_pkg::OP_PACK: begin
        if (!out_busy) begin
          rsp.timing_word   <= {presc, setup_delay, data_delay, 4'b0, high, low};
          rsp.used_fallback <= 1'b0;
        end
      end
      i2ctw_pkg::OP_FALLBK: begin
        if (!out_busy) begin
          rsp.timing_word   <= fallback_word;
          rsp.used_fallback <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/i2ctw_chk.sv
// Port-level checker for the I2C timing word calculator, bound to the top level.
// Depends on i2c_timing_word_calculator and the channel interfaces.
`default_nettype none
module i2ctw_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] timing_word,
  input wire logic        used_fallback
);

  // a request takes the sequencer out of the wait step, so requests are never taken back to back
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken back to back");

  // computed word leaves the spare nibble clear
  a_spare_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !used_fallback |-> timing_word[19:16] == 4'd0)
    else $error("spare bits set in computed word");

  // low count equals high count or exceeds it by one, and is nonzero
  a_split: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !used_fallback |->
      (timing_word[7:0] == timing_word[15:8] ||
       timing_word[7:0] == timing_word[15:8] + 8'd1) && timing_word[7:0] != 8'd0)
    else $error("bad high/low split");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(timing_word) && $stable(used_fallback))
    else $error("stalled response beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind i2c_timing_word_calculator i2ctw_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .timing_word   (rsp.timing_word),
  .used_fallback (rsp.used_fallback)
);
`default_nettype wire

>>> dv/i2c_timing_word_calculator_tb.sv
// Self-checking bench for the I2C timing word calculator: random and directed
// frequency pairs, register settings and back-pressure, checked beat by beat.
// Depends on i2ctw_pkg, the i2ctw_if channel interfaces and the calculator RTL.
`timescale 1ns / 100ps
module i2c_timing_word_calculator_tb;

  localparam int MAX_PRESCALER = 15;
  localparam logic [i2ctw_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int RANDOM_PER_PHASE = 140;
  localparam int RSP_HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 600;
  localparam longint unsigned CLK_MAX = 64'h3FFF_FFFF;
  localparam longint unsigned BUS_MAX = 64'hF_FFFF;

  typedef struct {
    logic [i2ctw_pkg::CLK_W-1:0] clock_hz;
    logic [i2ctw_pkg::BUS_W-1:0] bus_hz;
  } freq_pair_t;

  typedef struct {
    logic [i2ctw_pkg::WORD_W-1:0] word;
    logic                         fallback;
  } timing_t;

  logic clk;
  logic rst;

  i2ctw_req_if req_ch();
  i2ctw_rsp_if rsp_ch();
  i2ctw_cfg_if cfg_ch();

  i2c_timing_word_calculator #(.MAX_PRESCALER(MAX_PRESCALER)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  logic [i2ctw_pkg::WORD_W-1:0] fallback_reg;
  logic [i2ctw_pkg::DLY_W-1:0]  setup_reg;
  logic [i2ctw_pkg::DLY_W-1:0]  data_reg;

  freq_pair_t req_backlog[$];
  timing_t    word_due[$];
  freq_pair_t next_req;
  timing_t    due;
  logic       req_beat;
  int         idle_pct;
  int         n_issued;
  int         n_checked;
  int         n_errors;
  int         n_fallback;
  int         presc_hits[16];
  int         hold_req;
  int         hold_seen;
  int         hold_left;

  always #2 clk = ~clk;

  function automatic timing_t calc_timing(input logic [i2ctw_pkg::CLK_W-1:0] clock_hz,
                                          input logic [i2ctw_pkg::BUS_W-1:0] bus_hz);
    timing_t r;
    longint unsigned divisor;
    longint unsigned period;
    logic [7:0] lo;
    logic [7:0] hi;
    r.word = fallback_reg;
    r.fallback = 1'b1;
    if (clock_hz != 0 && bus_hz != 0) begin
      for (int p = 0; p <= MAX_PRESCALER; p++) begin
        divisor = longint'(p + 1) * longint'(bus_hz);
        period = longint'(clock_hz) / divisor;
        if (period >= i2ctw_pkg::MIN_PERIOD && period <= i2ctw_pkg::MAX_PERIOD) begin
          lo = 8'((period - 1) >> 1);   // ceil((period - 2) / 2)
          hi = 8'((period - 2) >> 1);
          r.word = {4'(p), setup_reg, data_reg, 4'h0, hi, lo};
          r.fallback = 1'b0;
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic freq_pair_t pick_freqs();
    freq_pair_t f;
    longint unsigned presc;
    longint unsigned period;
    longint unsigned bus_top;
    longint unsigned bus;
    int mode;
    mode = $urandom_range(99);
    if (mode < 70) begin
      // aim at a chosen prescaler and period, edges of the period range included
      presc = $urandom_range(MAX_PRESCALER);
      case ($urandom_range(5))
        0: period = $urandom_range(3, 5);
        1: period = $urandom_range(510, 513);
        default: period = $urandom_range(4, 512);
      endcase
      bus_top = CLK_MAX / ((presc + 1) * (period + 1));
      if (bus_top > BUS_MAX) bus_top = BUS_MAX;
      bus = ($urandom_range(3) == 0) ? $urandom_range(1, bus_top)
                                     : $urandom_range(1, (bus_top < 500000) ? bus_top : 500000);
      f.bus_hz = i2ctw_pkg::BUS_W'(bus);
      f.clock_hz = i2ctw_pkg::CLK_W'(period * (presc + 1) * bus +
                                     $urandom_range(0, (presc + 1) * bus - 1));
    end else if (mode < 85) begin
      f.clock_hz = i2ctw_pkg::CLK_W'($urandom);
      f.bus_hz = i2ctw_pkg::BUS_W'($urandom);
    end else if (mode < 93) begin
      f.clock_hz = ($urandom_range(1) == 0) ? '0 : i2ctw_pkg::CLK_W'($urandom);
      f.bus_hz = (f.clock_hz == 0) ? i2ctw_pkg::BUS_W'($urandom) : '0;
    end else begin
      f.clock_hz = i2ctw_pkg::CLK_W'($urandom);
      f.bus_hz = i2ctw_pkg::BUS_W'($urandom_range(1, 64));
    end
    return f;
  endfunction

  task automatic queue_req(input longint unsigned clock_hz, input longint unsigned bus_hz);
    freq_pair_t f;
    f.clock_hz = i2ctw_pkg::CLK_W'(clock_hz);
    f.bus_hz = i2ctw_pkg::BUS_W'(bus_hz);
    req_backlog.push_back(f);
  endtask

  task automatic report_mismatch(input string what, input logic [i2ctw_pkg::WORD_W-1:0] got,
                                 input logic [i2ctw_pkg::WORD_W-1:0] want);
    $display("%0t MISMATCH %s: got %h want %h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic write_reg(input logic [i2ctw_pkg::IDX_W-1:0] index,
                           input logic [i2ctw_pkg::WORD_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (index)
      i2ctw_pkg::REG_FALLBACK: fallback_reg = value;
      i2ctw_pkg::REG_SETUP:    setup_reg = value[i2ctw_pkg::DLY_W-1:0];
      i2ctw_pkg::REG_DATA:     data_reg = value[i2ctw_pkg::DLY_W-1:0];
      default:                 ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_beat) begin
      if (req_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_req = req_backlog.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.clock_hz <= next_req.clock_hz;
        req_ch.bus_hz <= next_req.bus_hz;
        n_issued++;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response back-pressure, with an on-demand long hold
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= RSP_HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor: predict on each request beat, check each response beat
  always @(posedge clk) begin
    req_beat <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready)
      word_due.push_back(calc_timing(req_ch.clock_hz, req_ch.bus_hz));
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (word_due.size() == 0) begin
        report_mismatch("result with nothing pending", rsp_ch.timing_word, '0);
      end else begin
        due = word_due.pop_front();
        if (rsp_ch.timing_word !== due.word)
          report_mismatch("timing_word", rsp_ch.timing_word, due.word);
        if (rsp_ch.used_fallback !== due.fallback)
          report_mismatch("used_fallback", i2ctw_pkg::WORD_W'(rsp_ch.used_fallback),
                          i2ctw_pkg::WORD_W'(due.fallback));
        if (due.fallback) n_fallback++;
        else presc_hits[due.word[31:28]]++;
      end
      n_checked++;
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int n_fit;
    clk = 1'b0;
    rst = 1'b1;
    req_beat = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.clock_hz = '0;
    req_ch.bus_hz = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = i2ctw_pkg::REG_FALLBACK;
    cfg_ch.data = '0;
    fallback_reg = i2ctw_pkg::FALLBACK_RESET;
    setup_reg = i2ctw_pkg::SETUP_RESET;
    data_reg = i2ctw_pkg::DATA_RESET;
    idle_pct = 10;
    n_issued = 0;
    n_checked = 0;
    n_errors = 0;
    n_fallback = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    foreach (presc_hits[i]) presc_hits[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          write_reg(i2ctw_pkg::REG_FALLBACK, '0);
          write_reg(i2ctw_pkg::REG_SETUP, '0);
          write_reg(i2ctw_pkg::REG_DATA, '0);
        end
        2: begin
          write_reg(i2ctw_pkg::REG_FALLBACK, '1);
          write_reg(i2ctw_pkg::REG_SETUP, 32'hF);
          write_reg(i2ctw_pkg::REG_DATA, 32'hF);
          write_reg(REG_UNUSED, $urandom);
        end
        3: begin
          write_reg(i2ctw_pkg::REG_FALLBACK, $urandom);
          write_reg(i2ctw_pkg::REG_SETUP, $urandom);
          write_reg(i2ctw_pkg::REG_DATA, $urandom);
        end
        4: begin
          write_reg(i2ctw_pkg::REG_FALLBACK, $urandom);
          write_reg(i2ctw_pkg::REG_SETUP, 32'hF);
          write_reg(i2ctw_pkg::REG_DATA, '0);
        end
        5: begin
          write_reg(i2ctw_pkg::REG_FALLBACK, $urandom);
          write_reg(i2ctw_pkg::REG_SETUP, '0);
          write_reg(i2ctw_pkg::REG_DATA, 32'hF);
        end
        default: ;
      endcase
      idle_pct = (ph == 3) ? 0 : 10;

      if (ph == 0) begin
        queue_req(0, 0);
        queue_req(0, BUS_MAX);
        queue_req(CLK_MAX, 0);
        queue_req(CLK_MAX, BUS_MAX);
        queue_req(CLK_MAX, 1);                 // ratio too large for any prescaler
        queue_req(1, 1);
        queue_req(3, 1);                       // period just below minimum
        queue_req(4, 1);                       // minimum period
        queue_req(5, 1);                       // odd split
        queue_req(512, 1);                     // widest counts at prescaler 0
        queue_req(513, 1);                     // spills into prescaler 1
        queue_req(16 * 512, 1);                // only the top prescaler fits
        queue_req(16 * 513, 1);                // just past the top prescaler
        queue_req(999, 250);
        queue_req(1000, 250);
        queue_req(48_000_000, 100_000);
        queue_req(48_000_000, 400_000);
        queue_req(64_000_000, 100_000);
        queue_req(16_000_000, 1_000_000);
        queue_req(CLK_MAX, 65_536);
      end
      repeat (RANDOM_PER_PHASE) req_backlog.push_back(pick_freqs());

      if (ph == 1) begin
        // stall the response side long enough for the block to back up
        while (n_checked < n_issued + 0 && n_issued < 3) @(posedge clk);
        @(posedge clk);
        hold_req++;
      end

      while (req_backlog.size() > 0 || n_checked < n_issued || req_ch.valid)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (word_due.size() != 0)
      report_mismatch("results never delivered", i2ctw_pkg::WORD_W'(word_due.size()), '0);

    n_fit = 0;
    foreach (presc_hits[i]) if (presc_hits[i] > 0) n_fit++;
    $display("Summary: %0d requests checked over %0d register settings, %0d fallbacks",
             n_checked, PHASES, n_fallback);
    $display("Summary: %0d of 16 prescalers produced a timing word, %0d mismatches",
             n_fit, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
